// File: rtl/rtfbcd_pkg.sv
// Shared types, constants and functions of the tag frame BCD encoder.
package rtfbcd_pkg;

  localparam int unsigned CARD_W     = 32;
  localparam int unsigned YEAR_W     = 16;
  localparam int unsigned ID_DIGITS  = 7;
  localparam int unsigned ID_BCD_W   = 4 * ID_DIGITS;
  localparam int unsigned YR_BCD_W   = 8;
  localparam int unsigned NUM_CELLS  = CARD_W;
  localparam logic [31:0] HEADER_RESET = 32'hBB02_14FF;

  typedef struct packed {
    logic [CARD_W-1:0] card_number;
    logic [YEAR_W-1:0] issue_year;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_word_first;
    logic [31:0] frame_word_middle;
    logic [31:0] frame_word_last;
  } out_item_t;

  typedef struct packed {
    logic [CARD_W-1:0]   id_bin;
    logic [CARD_W-1:0]   yr_bin;
    logic [ID_BCD_W-1:0] id_bcd;
    logic [YR_BCD_W-1:0] yr_bcd;
  } cell_data_t;

  // One double-dabble step: correct every digit of five or more by adding
  // three, then shift the next binary bit in at the bottom. Digits above the
  // seventh are dropped; lower digits never depend on higher ones.
  function automatic logic [ID_BCD_W-1:0] dd_step(input logic [ID_BCD_W-1:0] bcd,
                                                  input logic bin);
    logic [ID_BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < ID_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[ID_BCD_W-2:0], bin};
  endfunction

  // XOR of the eight nibbles of a 32-bit word.
  function automatic logic [3:0] nib_xor(input logic [31:0] w);
    logic [3:0] s;
    s = 4'h0;
    for (int i = 0; i < 8; i++) begin
      s = s ^ w[4*i +: 4];
    end
    return s;
  endfunction

endpackage

// File: rtl/rfid_tag_frame_bcd_encoder_unit.sv
// Top level of the tag frame encoder: a chain of BCD cells and the frame stage.
//
// Usage. A request word (card number and year) is taken at every rising edge
// at which start is high and busy is low. Busy is never raised, so a new word
// may be offered in every cycle. The block converts the card number to its low
// seven decimal digits and the year to its last two, using a row of 32
// identical double-dabble cells, one per binary bit, each passing its partial
// result to the next cell on every clock. The frame stage after the last cell
// builds the three 32-bit frame words and both nibble checksums.
// The path from the accepting edge to the strobe runs through the 32 cell stages
// and one output register. Throughput is one word per cycle, set by the cell chain
// holding one word in each stage.
// Each result is shown on out_item for exactly one cycle with out_strobe high;
// the receiver cannot stall the block, so it must take the word in that cycle.
// The header register is written through the cfg channel, which is always
// ready; it should only be changed while no request is in flight.
// Reset (synchronous, active low) empties the chain, drops any words in
// flight and restores the header to its default value.
module rfid_tag_frame_bcd_encoder_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  rtfbcd_pkg::in_item_t   in_item,
  output logic                   out_strobe,
  output rtfbcd_pkg::out_item_t  out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_header_word
);

  logic [31:0] header_r;
  logic [31:0] header_nxt;

  // Stage k of the chain is the input of cell k; the last entry feeds the frame stage.
  logic                   chain_valid [rtfbcd_pkg::NUM_CELLS+1];
  rtfbcd_pkg::cell_data_t chain_data  [rtfbcd_pkg::NUM_CELLS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Header register.
  always_comb begin
    header_nxt = header_r;
    if (cfg_valid && cfg_ready) begin
      header_nxt = cfg_header_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= rtfbcd_pkg::HEADER_RESET;
    end else begin
      header_r <= header_nxt;
    end
  end

  // The year is padded with leading zeros so that every cell treats both
  // values alike; zeros shifted in first leave the BCD value at zero.
  assign chain_valid[0] = start && !busy;
  assign chain_data[0]  = '{
    id_bin: in_item.card_number,
    yr_bin: {{(rtfbcd_pkg::CARD_W - rtfbcd_pkg::YEAR_W){1'b0}}, in_item.issue_year},
    id_bcd: '0,
    yr_bcd: '0
  };

  for (genvar k = 0; k < rtfbcd_pkg::NUM_CELLS; k++) begin : g_cell
    rtfbcd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (chain_valid[k]),
      .data_in   (chain_data[k]),
      .valid_out (chain_valid[k+1]),
      .data_out  (chain_data[k+1])
    );
  end

  rtfbcd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_in    (chain_valid[rtfbcd_pkg::NUM_CELLS]),
    .data_in     (chain_data[rtfbcd_pkg::NUM_CELLS]),
    .header_word (header_r),
    .out_strobe  (out_strobe),
    .out_item    (out_item)
  );

endmodule

// File: rtl/rtfbcd_cell.sv
// One conversion cell: takes one binary bit of card number and year into BCD.
module rtfbcd_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_in,
  input  rtfbcd_pkg::cell_data_t  data_in,
  output logic                    valid_out,
  output rtfbcd_pkg::cell_data_t  data_out
);

  logic                   valid_r;
  rtfbcd_pkg::cell_data_t data_r;
  rtfbcd_pkg::cell_data_t data_nxt;
  logic [rtfbcd_pkg::ID_BCD_W-1:0] yr_wide;

  always_comb begin
    yr_wide = {{(rtfbcd_pkg::ID_BCD_W - rtfbcd_pkg::YR_BCD_W){1'b0}}, data_in.yr_bcd};
    data_nxt.id_bin = {data_in.id_bin[rtfbcd_pkg::CARD_W-2:0], 1'b0};
    data_nxt.yr_bin = {data_in.yr_bin[rtfbcd_pkg::CARD_W-2:0], 1'b0};
    data_nxt.id_bcd = rtfbcd_pkg::dd_step(data_in.id_bcd,
                                          data_in.id_bin[rtfbcd_pkg::CARD_W-1]);
    data_nxt.yr_bcd = rtfbcd_pkg::YR_BCD_W'(rtfbcd_pkg::dd_step(
                        yr_wide, data_in.yr_bin[rtfbcd_pkg::CARD_W-1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

// File: rtl/rtfbcd_frame.sv
// Output stage: places the digits, computes both checksums and registers the word.
module rtfbcd_frame (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_in,
  input  rtfbcd_pkg::cell_data_t  data_in,
  input  logic [31:0]             header_word,
  output logic                    out_strobe,
  output rtfbcd_pkg::out_item_t   out_item
);

  logic                  strobe_r;
  rtfbcd_pkg::out_item_t item_r;
  rtfbcd_pkg::out_item_t item_nxt;
  logic [31:0] middle;
  logic [7:0]  low2;
  logic [3:0]  chk1;
  logic [3:0]  chk2;

  always_comb begin
    middle = {data_in.id_bcd[27:16], data_in.yr_bcd, 4'h0, data_in.id_bcd[15:8]};
    low2   = data_in.id_bcd[7:0];
    chk1   = rtfbcd_pkg::nib_xor(middle) ^ low2[7:4] ^ low2[3:0];
    chk2   = rtfbcd_pkg::nib_xor(header_word) ^ rtfbcd_pkg::nib_xor(middle)
           ^ low2[7:4] ^ low2[3:0] ^ chk1;
    item_nxt.frame_word_first  = header_word;
    item_nxt.frame_word_middle = middle;
    item_nxt.frame_word_last   = {low2, chk1, chk2, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule
